// ===== rtl/bitmap_canvas_draw_engine_defines.svh =====
// assertion helpers
`ifndef BITMAP_CANVAS_DRAW_ENGINE_DEFINES_SVH
`define BITMAP_CANVAS_DRAW_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define BCDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`define BCDE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define BCDE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons)
`endif
`endif

// ===== rtl/bcde_pkg.sv =====
package bcde_pkg;
    localparam int COORD_W = 10;
    localparam int RAD_W   = 6;
    localparam int DIM_W   = 7;
    localparam int QDEPTH  = 2;

    localparam logic [2:0] OP_CLEAR_ALL = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_ROW_FILL  = 3'd4;
    localparam logic [2:0] OP_COL_FILL  = 3'd5;
    localparam logic [2:0] OP_DISC      = 3'd6;
    localparam logic [2:0] OP_SEGMENT   = 3'd7;

    localparam logic [7:0] PIX_CLEARED = 8'd255;
    localparam logic [7:0] PIX_SET     = 8'd1;
    localparam logic [7:0] PIX_OFF     = 8'd0;

    typedef logic signed [11:0] coord_t;

    typedef struct packed {
        logic [2:0]                op;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [RAD_W-1:0]          radius;
        logic                      err;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic [DIM_W-1:0] uw;
        logic [DIM_W-1:0] uh;
    } dims_t;

    function automatic coord_t ext12(input logic signed [COORD_W-1:0] v);
        return {{(12-COORD_W){v[COORD_W-1]}}, v};
    endfunction
endpackage

// ===== rtl/bcde_front.sv =====
module bcde_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_op,
    input  logic signed [bcde_pkg::COORD_W-1:0] s_x0,
    input  logic signed [bcde_pkg::COORD_W-1:0] s_y0,
    input  logic signed [bcde_pkg::COORD_W-1:0] s_x1,
    input  logic signed [bcde_pkg::COORD_W-1:0] s_y1,
    input  logic [bcde_pkg::RAD_W-1:0]         s_radius,
    input  bcde_pkg::dims_t                    dims,
    output bcde_pkg::q_head_t                  head,
    input  logic                               pop
);
    import bcde_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    cmd_t            cmd_in;
    cmd_t            q_mem [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            push;
    logic signed [11:0] x0e, y0e, uws, uhs;
    logic            x_ok, y_ok;

    always_comb begin
        x0e  = ext12(s_x0);
        y0e  = ext12(s_y0);
        uws  = {5'b0, dims.uw};
        uhs  = {5'b0, dims.uh};
        x_ok = (x0e >= 0) && (x0e < uws);
        y_ok = (y0e >= 0) && (y0e < uhs);
        cmd_in.op     = s_op;
        cmd_in.x0     = s_x0;
        cmd_in.y0     = s_y0;
        cmd_in.x1     = s_x1;
        cmd_in.y1     = s_y1;
        cmd_in.radius = s_radius;
        case (s_op)
            OP_SET, OP_CLEAR, OP_READ: cmd_in.err = !(x_ok && y_ok);
            OP_ROW_FILL: cmd_in.err = !y_ok || (dims.uw == '0);
            OP_COL_FILL: cmd_in.err = !x_ok || (dims.uh == '0);
            default: cmd_in.err = 1'b0;
        endcase
    end

    assign s_ready    = (cnt_reg != CNTW'(QDEPTH));
    assign push       = s_valid && s_ready;
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNTW'(push) - CNTW'(pop);
        end
    end
endmodule

// ===== rtl/bcde_back.sv =====
module bcde_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bcde_pkg::q_head_t head,
    output logic              pop,
    input  bcde_pkg::dims_t   dims,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status,
    output logic [7:0]        m_pixel
);
    import bcde_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SWEEP   = 4'd1;
    localparam logic [3:0] S_PIX     = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_RDW     = 4'd4;
    localparam logic [3:0] S_ROW     = 4'd5;
    localparam logic [3:0] S_COL     = 4'd6;
    localparam logic [3:0] S_ST_INIT = 4'd7;
    localparam logic [3:0] S_ST_SCAN = 4'd8;
    localparam logic [3:0] S_SG_MUL  = 4'd9;
    localparam logic [3:0] S_SG_CMP  = 4'd10;
    localparam logic [3:0] S_SG_NEXT = 4'd11;
    localparam logic [3:0] S_VT_NEXT = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]  state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic        from_cmd_reg, from_cmd_next;
    logic [AW-1:0] ctr_reg, ctr_next;
    logic [DIM_W-1:0] i_reg, i_next;
    coord_t      cx_reg, cx_next, cy_reg, cy_next;
    coord_t      px_reg, px_next, py_reg, py_next;
    coord_t      clo_reg, clo_next, chi_reg, chi_next, lhi_reg, lhi_next;
    logic        empty_reg, empty_next;
    coord_t      sx_reg, sx_next, sy_reg, sy_next, xb_reg, xb_next, hi_reg, hi_next;
    logic signed [23:0] pa_reg, pa_next, pb_reg, pb_next;
    logic        res_valid_reg, res_valid_next;
    logic        res_status_reg, res_status_next;
    logic [7:0]  res_pixel_reg, res_pixel_next;

    logic [7:0]    mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    coord_t cx0, cy0, cx1, cy1, rr, hmax, wmax, dx, dy, adx;
    coord_t t_lo, t_hi, c_lo, c_hi, llo, lhi, clo, chi;
    coord_t dl, dc;
    coord_t h_x0, h_x1, h_y0, h_y1, h_ylo, h_yhi, h_vlo, h_vhi;
    logic signed [7:0]  dl8, dc8;
    logic [16:0]        d2;
    logic [11:0]        r2;
    logic signed [24:0] tval, tabs;
    logic [3:0]         ret_state;

    function automatic logic [AW-1:0] addr_of(input coord_t col, input coord_t line);
        logic [LW-1:0] l;
        logic [CW-1:0] c;
        l = line[LW-1:0];
        c = col[CW-1:0];
        return AW'(l * MAX_WIDTH + c);
    endfunction

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    assign pop      = (state_reg == S_IDLE) && head.valid && !res_valid_reg;
    assign m_valid  = res_valid_reg;
    assign m_status = res_status_reg;
    assign m_pixel  = res_pixel_reg;

    always_comb begin
        cx0  = ext12(cmd_reg.x0);
        cy0  = ext12(cmd_reg.y0);
        cx1  = ext12(cmd_reg.x1);
        cy1  = ext12(cmd_reg.y1);
        rr   = {6'b0, cmd_reg.radius};
        r2   = 12'(cmd_reg.radius * cmd_reg.radius);
        hmax = {5'b0, dims.uh} - 12'sd1;
        wmax = {5'b0, dims.uw} - 12'sd1;
        dx   = cx1 - cx0;
        dy   = cy1 - cy0;
        adx  = (dx < 0) ? -dx : dx;
        t_lo = cy_reg - rr + 12'sd1;
        t_hi = cy_reg + rr - 12'sd1;
        c_lo = cx_reg - rr + 12'sd1;
        c_hi = cx_reg + rr - 12'sd1;
        llo  = (t_lo < 0) ? '0 : t_lo;
        lhi  = (t_hi > hmax) ? hmax : t_hi;
        clo  = (c_lo < 0) ? '0 : c_lo;
        chi  = (c_hi > wmax) ? wmax : c_hi;
        dl   = py_reg - cy_reg;
        dc   = px_reg - cx_reg;
        dl8  = dl[7:0];
        dc8  = dc[7:0];
        d2   = 17'(16'(dl8 * dl8)) + 17'(16'(dc8 * dc8));
        tval = 25'(pa_reg) - 25'(pb_reg);
        tabs = (tval < 0) ? -tval : tval;
        h_x0  = ext12(head.cmd.x0);
        h_x1  = ext12(head.cmd.x1);
        h_y0  = ext12(head.cmd.y0);
        h_y1  = ext12(head.cmd.y1);
        h_ylo = (h_y0 < h_y1) ? h_y0 : h_y1;
        h_yhi = (h_y0 < h_y1) ? h_y1 : h_y0;
        h_vlo = (h_ylo < 0) ? '0 : h_ylo;
        h_vhi = (h_yhi > hmax) ? hmax : h_yhi;
        if (cmd_reg.op == OP_DISC) begin
            ret_state = S_DONE;
        end else if (cmd_reg.x0 == cmd_reg.x1) begin
            ret_state = S_VT_NEXT;
        end else begin
            ret_state = S_SG_NEXT;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        from_cmd_next   = from_cmd_reg;
        ctr_next        = ctr_reg;
        i_next          = i_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        clo_next        = clo_reg;
        chi_next        = chi_reg;
        lhi_next        = lhi_reg;
        empty_next      = empty_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        xb_next         = xb_reg;
        hi_next         = hi_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_pixel_next  = res_pixel_reg;
        mem_we          = 1'b0;
        mem_addr        = addr_of(cx0, cy0);
        mem_wdata       = PIX_SET;
        if (res_valid_reg && m_ready) begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    cmd_next        = head.cmd;
                    from_cmd_next   = 1'b1;
                    res_status_next = head.cmd.err;
                    res_pixel_next  = PIX_OFF;
                    state_next      = S_DONE;
                    if (!head.cmd.err) begin
                        case (head.cmd.op)
                            OP_CLEAR_ALL: begin
                                ctr_next   = '0;
                                state_next = S_SWEEP;
                            end
                            OP_SET, OP_CLEAR: state_next = S_PIX;
                            OP_READ: state_next = S_RD;
                            OP_ROW_FILL: begin
                                i_next     = '0;
                                state_next = S_ROW;
                            end
                            OP_COL_FILL: begin
                                i_next     = '0;
                                state_next = S_COL;
                            end
                            OP_DISC: begin
                                cx_next    = ext12(head.cmd.x0);
                                cy_next    = ext12(head.cmd.y0);
                                state_next = S_ST_INIT;
                            end
                            OP_SEGMENT: begin
                                if (head.cmd.radius != '0) begin
                                    if (head.cmd.x0 == head.cmd.x1) begin
                                        cx_next = h_x0;
                                        cy_next = h_vlo;
                                        hi_next = h_vhi;
                                        if (h_vlo <= h_vhi) begin
                                            state_next = S_ST_INIT;
                                        end
                                    end else begin
                                        sx_next = (h_x0 < h_x1) ? h_x0 : h_x1;
                                        xb_next = (h_x0 < h_x1) ? h_x1 : h_x0;
                                        sy_next = '0;
                                        if (dims.uh != '0) begin
                                            state_next = S_SG_MUL;
                                        end
                                    end
                                end
                            end
                            default: state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_addr  = ctr_reg;
                mem_wdata = PIX_CLEARED;
                ctr_next  = ctr_reg + 1'b1;
                if (ctr_reg == AW'(DEPTH - 1)) begin
                    state_next = from_cmd_reg ? S_DONE : S_IDLE;
                end
            end
            S_PIX: begin
                mem_we     = 1'b1;
                mem_wdata  = (cmd_reg.op == OP_SET) ? PIX_SET : PIX_OFF;
                state_next = S_DONE;
            end
            S_RD: state_next = S_RDW;
            S_RDW: begin
                res_pixel_next = mem_rdata;
                state_next     = S_DONE;
            end
            S_ROW: begin
                mem_we   = 1'b1;
                mem_addr = addr_of({5'b0, i_reg}, cy0);
                i_next   = i_reg + 1'b1;
                if (i_reg == dims.uw - 1'b1) begin
                    state_next = S_DONE;
                end
            end
            S_COL: begin
                mem_we   = 1'b1;
                mem_addr = addr_of(cx0, {5'b0, i_reg});
                i_next   = i_reg + 1'b1;
                if (i_reg == dims.uh - 1'b1) begin
                    state_next = S_DONE;
                end
            end
            S_ST_INIT: begin
                py_next    = llo;
                px_next    = clo;
                clo_next   = clo;
                chi_next   = chi;
                lhi_next   = lhi;
                empty_next = (llo > lhi) || (clo > chi);
                state_next = S_ST_SCAN;
            end
            S_ST_SCAN: begin
                if (empty_reg) begin
                    state_next = ret_state;
                end else begin
                    mem_addr = addr_of(px_reg, py_reg);
                    mem_we   = (d2 < {5'b0, r2});
                    if (px_reg == chi_reg) begin
                        px_next = clo_reg;
                        py_next = py_reg + 12'sd1;
                        if (py_reg == lhi_reg) begin
                            state_next = ret_state;
                        end
                    end else begin
                        px_next = px_reg + 12'sd1;
                    end
                end
            end
            S_SG_MUL: begin
                pa_next    = (sy_reg - cy1) * dx;
                pb_next    = dy * (sx_reg - cx1);
                state_next = S_SG_CMP;
            end
            S_SG_CMP: begin
                if (tabs < 25'(adx)) begin
                    cx_next    = sx_reg;
                    cy_next    = sy_reg;
                    state_next = S_ST_INIT;
                end else begin
                    state_next = S_SG_NEXT;
                end
            end
            S_SG_NEXT: begin
                state_next = S_SG_MUL;
                if (sy_reg == hmax) begin
                    sy_next = '0;
                    sx_next = sx_reg + 12'sd1;
                    if (sx_reg == xb_reg) begin
                        state_next = S_DONE;
                    end
                end else begin
                    sy_next = sy_reg + 12'sd1;
                end
            end
            S_VT_NEXT: begin
                if (cy_reg == hi_reg) begin
                    state_next = S_DONE;
                end else begin
                    cy_next    = cy_reg + 12'sd1;
                    state_next = S_ST_INIT;
                end
            end
            S_DONE: begin
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            from_cmd_reg  <= 1'b0;
            ctr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            from_cmd_reg  <= from_cmd_next;
            ctr_reg       <= ctr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        i_reg          <= i_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        clo_reg        <= clo_next;
        chi_reg        <= chi_next;
        lhi_reg        <= lhi_next;
        empty_reg      <= empty_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        res_status_reg <= res_status_next;
        res_pixel_reg  <= res_pixel_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        xb_reg         <= xb_next;
        hi_reg         <= hi_next;
    end
endmodule

// ===== rtl/bitmap_canvas_draw_engine.sv =====
// Draw engine over an 8-bit canvas held in one on-chip memory (MAX_WIDTH x MAX_HEIGHT,
// row stride MAX_WIDTH). After reset the memory is swept to 255, one pixel a cycle, over
// all MAX_WIDTH*MAX_HEIGHT pixels; command words that arrive meanwhile wait in the queue
// and run after the sweep. Clear-all repeats that sweep. Commands enter a two-word queue
// and run one at a time in a sequencer that touches at most one pixel per cycle through
// the memory port: set/clear write one pixel, read fetches one, row or column fill cover
// the used width or height, a disc scans up to (2r-1)^2 pixels (fewer where the canvas
// edge clips it), a segment tests (|x1-x0|+1) x height candidate centres (or each row of
// a vertical span) plus a disc scan per hit. One result word per command; a waiting
// result holds off the next command.
`include "bitmap_canvas_draw_engine_defines.svh"
module bitmap_canvas_draw_engine #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x0[9:0], y0[19:10], x1[29:20], y1[39:30], radius[45:40], zero fill
    input  logic [47:0] s_tdata,
    // op[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value[7:0]
    output logic [7:0]  m_tdata,
    // status[0]
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcde_pkg::*;

    logic [DIM_W-1:0] cw_reg, ch_reg;
    dims_t            dims;
    q_head_t          head;
    logic             pop;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {25'b0, ch_reg} : {25'b0, cw_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= DIM_W'(64);
            ch_reg <= DIM_W'(64);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                ch_reg <= pwdata[DIM_W-1:0];
            end else begin
                cw_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign dims.uw = (cw_reg > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cw_reg;
    assign dims.uh = (ch_reg > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : ch_reg;

    bcde_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_op     (s_tuser),
        .s_x0     (s_tdata[9:0]),
        .s_y0     (s_tdata[19:10]),
        .s_x1     (s_tdata[29:20]),
        .s_y1     (s_tdata[39:30]),
        .s_radius (s_tdata[45:40]),
        .dims     (dims),
        .head     (head),
        .pop      (pop)
    );

    bcde_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .dims     (dims),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_status (m_tuser[0]),
        .m_pixel  (m_tdata)
    );

    `BCDE_ASSERT_NEXT(a_cfg_width, aclk, aresetn, cfg_wr && !paddr[2], cw_reg == $past(pwdata[6:0]))
    `BCDE_ASSERT_NEXT(a_cfg_height, aclk, aresetn, cfg_wr && paddr[2], ch_reg == $past(pwdata[6:0]))
    `BCDE_ASSERT_ALWAYS_NEXT(a_reset_quiet, aclk, !aresetn, !m_tvalid)
endmodule
